// File: hw/rtl/rft_pkg.sv
package rft_pkg;

  localparam int ID_BITS     = 16;
  localparam int TABLE_DEPTH = 1 << ID_BITS;
  localparam int PORT_W      = 16;
  localparam int CFG_W       = 16;

  localparam logic [PORT_W-1:0] NO_PORT = '1;

  localparam logic [1:0] MODE_HEADER = 2'd0;
  localparam logic [1:0] MODE_UPDATE = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;

  localparam logic [1:0] ACT_NONE    = 2'd0;
  localparam logic [1:0] ACT_DELIVER = 2'd1;
  localparam logic [1:0] ACT_FORWARD = 2'd2;
  localparam logic [1:0] ACT_DROP    = 2'd3;

  localparam logic CFG_MY_ROUTER_ID   = 1'b0;
  localparam logic CFG_DATA_TYPE_CODE = 1'b1;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] dest_id;
    logic [15:0] arrival_port;
    logic [7:0]  packet_type;
    logic [15:0] next_port;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] out_port;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic clear;
    logic exec;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
  } stat_t;

endpackage

// File: hw/rtl/rft_ctrl.sv
module rft_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  rft_pkg::stat_t stat,
  output rft_pkg::cmd_t  cmd,
  output logic          busy
);
  import rft_pkg::*;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t state;

  always_comb begin
    cmd.load  = (state == ST_IDLE) && start;
    cmd.clear = (state == ST_CLEAR);
    cmd.exec  = (state == ST_EXEC);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      busy  <= 1'b1;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          if (stat.clear_last) begin
            state <= ST_IDLE;
            busy  <= 1'b0;
          end
        end
        ST_IDLE: begin
          if (start) begin
            state <= ST_EXEC;
            busy  <= 1'b1;
          end
        end
        ST_EXEC: begin
          state <= ST_IDLE;
          busy  <= 1'b0;
        end
        default: begin
          state <= ST_CLEAR;
          busy  <= 1'b1;
        end
      endcase
    end
  end

endmodule

// File: hw/rtl/rft_dp.sv
module rft_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  rft_pkg::cmd_t                cmd,
  output rft_pkg::stat_t               stat,
  input  rft_pkg::in_item_t            in_item,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [rft_pkg::CFG_W-1:0]    cfg_data,
  output logic                         done,
  output rft_pkg::out_item_t           result
);
  import rft_pkg::*;

  logic [15:0]        my_router_id;
  logic [7:0]         data_type_code;
  logic [ID_BITS-1:0] clr_cnt;

  // table word: valid mark above the stored port
  logic [PORT_W:0]    mem [TABLE_DEPTH];
  logic [PORT_W:0]    rd_word;
  in_item_t           item;

  logic               mem_we;
  logic [ID_BITS-1:0] mem_waddr;
  logic [PORT_W:0]    mem_wdata;
  logic [ID_BITS-1:0] item_idx;
  logic               hit;
  out_item_t          result_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      my_router_id   <= '0;
      data_type_code <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MY_ROUTER_ID:   my_router_id   <= cfg_data[15:0];
        CFG_DATA_TYPE_CODE: data_type_code <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  assign stat.clear_last = (clr_cnt == '1);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= in_item;
    end
  end

  assign item_idx = item.dest_id[ID_BITS-1:0];
  assign hit      = rd_word[PORT_W] && (rd_word[PORT_W-1:0] != NO_PORT);

  always_comb begin
    result_next.action   = ACT_NONE;
    result_next.out_port = NO_PORT;
    mem_we    = 1'b0;
    mem_waddr = item_idx;
    mem_wdata = '0;
    if (cmd.clear) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt;
    end else if (cmd.exec) begin
      case (item.mode)
        MODE_UPDATE: begin
          mem_we    = 1'b1;
          mem_wdata = {1'b1, item.next_port};
        end
        MODE_REMOVE: begin
          mem_we = hit;
        end
        MODE_HEADER: begin
          if (item.packet_type == data_type_code) begin
            // a locally generated packet always goes through the lookup
            if ((item.arrival_port != NO_PORT) && (item.dest_id == my_router_id)) begin
              result_next.action = ACT_DELIVER;
            end else if (hit) begin
              result_next.action   = ACT_FORWARD;
              result_next.out_port = rd_word[PORT_W-1:0];
            end else begin
              result_next.action = ACT_DROP;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.load) begin
      rd_word <= mem[in_item.dest_id[ID_BITS-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.exec;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      result <= result_next;
    end
  end

endmodule

// File: hw/rtl/router_forwarding_table_unit.sv
// Channel   Ports                              Transfer
// input     start, busy, in_item               start high and busy low at clk edge
// result    done, result                       done high for one cycle, always taken
// config    cfg_we, cfg_index, cfg_data        cfg_we high at clk edge
//
// On acceptance the item and its table read are registered; in the exec state
// the result is formed and any table write is done, and done and result are
// registered from it. After reset a clearing pass writes every table entry,
// one per cycle (2^ID_BITS entries); busy stays high until it ends.
// The result side cannot stall; a new item may be taken while done is high.
module router_forwarding_table_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  rft_pkg::in_item_t         in_item,
  output logic                      done,
  output rft_pkg::out_item_t        result,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [rft_pkg::CFG_W-1:0] cfg_data
);
  import rft_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  rft_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  rft_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .done      (done),
    .result    (result)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted transfer");

  a_done_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(start && !busy, 2) && !busy))
    else $error("result strobe without matching accepted item");

  a_port_forward: assert property (@(posedge clk) disable iff (rst)
    done |-> ((result.action == ACT_FORWARD) == (result.out_port != NO_PORT)))
    else $error("out_port inconsistent with action");

  a_clear_no_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |-> (!cmd.exec && !cmd.load && busy))
    else $error("item handled during clearing pass");

endmodule
